// ===== src/rgbfs_pkg.sv =====
package rgbfs_pkg;

  localparam int PIX_W     = 24;
  localparam int BIT_CNT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PIX_W - 1);

  // command codes
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_SHOW = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_BUSY  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH      = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] lit_count;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       line_level;
    logic       frame_done;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [15:0] latch;
  } timing_t;

  typedef struct packed {
    logic start;
    logic load;
    logic tick;
  } wave_ctrl_t;

  typedef struct packed {
    logic sending;
    logic level;
    logic done;
  } wave_stat_t;

  typedef struct packed {
    logic set_en;
    logic fill_start;
  } store_req_t;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_LATCH
  } phase_t;

  typedef enum logic [1:0] {
    S_READY,
    S_SWEEP,
    S_LOAD_A,
    S_LOAD_D
  } ctl_state_t;

endpackage

// ===== src/rgb_led_strip_frame_serializer.sv =====
// Single-wire RGB LED strip serializer. Each input word is a command (set one
// LED, fill and show, show) or one time tick, and yields exactly one result
// word. Tick words are taken one per cycle in S_READY unless out_stall holds
// the result; each tick advances the line by one timing unit, sending every
// LED as R, G, B bytes MSB first and ending with a low latch gap. A show
// preloads the first LED from pixel memory via S_LOAD_A and S_LOAD_D; a fill
// sweeps the memory, one entry per cycle, and holds off input until the sweep
// and preload end. After reset a clearing pass zeroes the memory before the
// first word is taken; configuration writes are taken at any time. While a
// frame is in progress, set, fill and show are refused with the busy status.
module rgb_led_strip_frame_serializer #(
  parameter int LED_SLOTS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rgbfs_pkg::in_word_t              in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rgbfs_pkg::out_word_t             out_word,
  input  logic                             cfg_we,
  input  logic [rgbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbfs_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import rgbfs_pkg::*;

  localparam int AW = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
  localparam int CW = ($clog2(LED_SLOTS + 1) > 9) ? $clog2(LED_SLOTS + 1) : 9;
  localparam logic [CW-1:0] MAX_C = CW'(LED_SLOTS);

  logic [8:0] led_count_r;
  timing_t    timing_r;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  logic          in_acc;
  logic [CW-1:0] active;
  logic [CW-1:0] lit_w;
  logic [CW-1:0] fill_lim;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] led_next;
  logic [PIX_W-1:0] rd_pix;
  logic          store_busy;
  store_req_t    sreq;
  wave_ctrl_t    wctrl;
  wave_stat_t    wstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r        <= 9'd256;
      timing_r.zero_high <= 8'd3;
      timing_r.zero_low  <= 8'd9;
      timing_r.one_high  <= 8'd9;
      timing_r.one_low   <= 8'd3;
      timing_r.latch     <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LED_COUNT: led_count_r        <= cfg_data[8:0];
        REG_ZERO_HIGH: timing_r.zero_high <= cfg_data[7:0];
        REG_ZERO_LOW:  timing_r.zero_low  <= cfg_data[7:0];
        REG_ONE_HIGH:  timing_r.one_high  <= cfg_data[7:0];
        REG_ONE_LOW:   timing_r.one_low   <= cfg_data[7:0];
        REG_LATCH:     timing_r.latch     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign active   = (CW'(led_count_r) > MAX_C) ? MAX_C : CW'(led_count_r);
  assign lit_w    = CW'(in_word.lit_count);
  assign fill_lim = (lit_w < active) ? lit_w : active;

  assign in_stall = (state_r != S_READY) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt        = state_r;
    sreq.set_en      = 1'b0;
    sreq.fill_start  = 1'b0;
    wctrl.start      = 1'b0;
    wctrl.load       = 1'b0;
    wctrl.tick       = 1'b0;
    rd_addr          = led_next;
    out_valid_nxt    = out_valid_r && out_stall;
    out_word_nxt     = out_word_r;
    unique case (state_r)
      S_READY: begin
        if (in_acc) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.status     = STS_OK;
          out_word_nxt.line_level = wstat.level;
          out_word_nxt.frame_done = 1'b0;
          priority if (in_word.cmd == CMD_TICK) begin
            wctrl.tick              = 1'b1;
            out_word_nxt.frame_done = wstat.done;
          end else if (wstat.sending) begin
            out_word_nxt.status = STS_BUSY;
          end else if (in_word.cmd == CMD_SET) begin
            if (CW'(in_word.led_index) < active) begin
              sreq.set_en = 1'b1;
            end else begin
              out_word_nxt.status = STS_RANGE;
            end
          end else begin
            wctrl.start             = 1'b1;
            out_word_nxt.line_level = (active != '0);
            if (in_word.cmd == CMD_FILL) begin
              sreq.fill_start = 1'b1;
              state_nxt       = S_SWEEP;
            end else begin
              state_nxt = S_LOAD_A;
            end
          end
        end
      end
      S_SWEEP: begin
        if (!store_busy) begin
          state_nxt = wstat.sending ? S_LOAD_A : S_READY;
        end
      end
      S_LOAD_A: begin
        // fetch the first LED of the frame
        rd_addr   = '0;
        state_nxt = S_LOAD_D;
      end
      S_LOAD_D: begin
        wctrl.load = 1'b1;
        state_nxt  = S_READY;
      end
      default: begin
        state_nxt = S_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  rgbfs_store #(
    .LED_SLOTS (LED_SLOTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sreq),
    .set_addr (AW'(in_word.led_index)),
    .wr_pix   ({in_word.red, in_word.green, in_word.blue}),
    .fill_lim (fill_lim),
    .rd_addr  (rd_addr),
    .rd_pix   (rd_pix),
    .busy     (store_busy)
  );

  rgbfs_wave #(
    .LED_SLOTS (LED_SLOTS)
  ) u_wave (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (wctrl),
    .timing   (timing_r),
    .active   (active),
    .pix      (rd_pix),
    .led_next (led_next),
    .stat     (wstat)
  );

endmodule

// ===== src/rgbfs_store.sv =====
module rgbfs_store #(
  parameter int LED_SLOTS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rgbfs_pkg::store_req_t          req,
  input  logic [((LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1)-1:0] set_addr,
  input  logic [rgbfs_pkg::PIX_W-1:0]    wr_pix,
  input  logic [(($clog2(LED_SLOTS + 1) > 9) ? $clog2(LED_SLOTS + 1) : 9)-1:0] fill_lim,
  input  logic [((LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1)-1:0] rd_addr,
  output logic [rgbfs_pkg::PIX_W-1:0]    rd_pix,
  output logic                           busy
);
  import rgbfs_pkg::*;

  localparam int AW = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
  localparam int CW = ($clog2(LED_SLOTS + 1) > 9) ? $clog2(LED_SLOTS + 1) : 9;
  localparam logic [AW-1:0] LAST_ADDR = AW'(LED_SLOTS - 1);

  logic [PIX_W-1:0] mem [LED_SLOTS];
  logic [PIX_W-1:0] rd_pix_r;

  logic             sweep_r, sweep_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    lim_r, lim_nxt;
  logic [PIX_W-1:0] col_r, col_nxt;

  logic             we;
  logic [AW-1:0]    wa;
  logic [PIX_W-1:0] wd;

  // sweep writes every entry; entries below the limit take the fill color
  always_comb begin
    sweep_nxt = sweep_r;
    cnt_nxt   = cnt_r;
    lim_nxt   = lim_r;
    col_nxt   = col_r;
    if (req.fill_start) begin
      sweep_nxt = 1'b1;
      cnt_nxt   = '0;
      lim_nxt   = fill_lim;
      col_nxt   = wr_pix;
    end else if (sweep_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_ADDR) begin
        sweep_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    wa = set_addr;
    wd = wr_pix;
    if (sweep_r) begin
      we = 1'b1;
      wa = cnt_r;
      wd = (CW'(cnt_r) < lim_r) ? col_r : '0;
    end else if (req.set_en) begin
      we = 1'b1;
    end
  end

  // reset starts a clearing pass (limit zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= 1'b1;
      cnt_r   <= '0;
      lim_r   <= '0;
    end else begin
      sweep_r <= sweep_nxt;
      cnt_r   <= cnt_nxt;
      lim_r   <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_pix_r <= mem[rd_addr];
  end

  assign rd_pix = rd_pix_r;
  assign busy   = sweep_r;

endmodule

// ===== src/rgbfs_wave.sv =====
module rgbfs_wave #(
  parameter int LED_SLOTS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rgbfs_pkg::wave_ctrl_t          ctrl,
  input  rgbfs_pkg::timing_t             timing,
  input  logic [(($clog2(LED_SLOTS + 1) > 9) ? $clog2(LED_SLOTS + 1) : 9)-1:0] active,
  input  logic [rgbfs_pkg::PIX_W-1:0]    pix,
  output logic [((LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1)-1:0] led_next,
  output rgbfs_pkg::wave_stat_t          stat
);
  import rgbfs_pkg::*;

  localparam int AW = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
  localparam int CW = ($clog2(LED_SLOTS + 1) > 9) ? $clog2(LED_SLOTS + 1) : 9;

  logic                 sending_r, sending_nxt;
  phase_t               phase_r, phase_nxt;
  logic [15:0]          pt_r, pt_nxt;
  logic [AW-1:0]        led_r, led_nxt;
  logic [BIT_CNT_W-1:0] bit_r, bit_nxt;
  logic [PIX_W-1:0]     shift_r, shift_nxt;

  logic        cur_bit;
  logic [7:0]  dur8;
  logic [15:0] dur_raw;
  logic [15:0] dur;
  logic [15:0] pt_inc;
  logic        ph_end;
  logic        last_led;

  assign cur_bit = shift_r[PIX_W-1];
  assign pt_inc  = pt_r + 16'd1;

  always_comb begin
    dur8 = cur_bit ? timing.one_high : timing.zero_high;
    unique case (phase_r)
      PH_HIGH:  dur_raw = {8'd0, dur8};
      PH_LOW:   dur_raw = {8'd0, cur_bit ? timing.one_low : timing.zero_low};
      PH_LATCH: dur_raw = timing.latch;
      default:  dur_raw = timing.latch;
    endcase
    dur = (dur_raw == 16'd0) ? 16'd1 : dur_raw;
  end

  assign ph_end   = (pt_inc == 16'd0) || (pt_inc >= dur);
  assign last_led = (CW'(led_r) + 1'b1) >= active;

  always_comb begin
    sending_nxt = sending_r;
    phase_nxt   = phase_r;
    pt_nxt      = pt_r;
    led_nxt     = led_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    if (ctrl.start) begin
      sending_nxt = 1'b1;
      phase_nxt   = (active == '0) ? PH_LATCH : PH_HIGH;
      pt_nxt      = '0;
      led_nxt     = '0;
      bit_nxt     = '0;
    end else if (ctrl.load) begin
      shift_nxt = pix;
    end else if (ctrl.tick && sending_r) begin
      if (!ph_end) begin
        pt_nxt = pt_inc;
      end else begin
        pt_nxt = '0;
        unique case (phase_r)
          PH_HIGH: begin
            phase_nxt = PH_LOW;
          end
          PH_LATCH: begin
            sending_nxt = 1'b0;
            phase_nxt   = PH_HIGH;
          end
          default: begin
            phase_nxt = PH_HIGH;
            if (bit_r != LAST_BIT) begin
              bit_nxt   = bit_r + 1'b1;
              shift_nxt = {shift_r[PIX_W-2:0], 1'b0};
            end else begin
              bit_nxt = '0;
              if (last_led) begin
                phase_nxt = PH_LATCH;
              end else begin
                // next word was prefetched at led_next
                led_nxt   = led_r + 1'b1;
                shift_nxt = pix;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      phase_r   <= PH_HIGH;
      pt_r      <= '0;
      led_r     <= '0;
      bit_r     <= '0;
    end else begin
      sending_r <= sending_nxt;
      phase_r   <= phase_nxt;
      pt_r      <= pt_nxt;
      led_r     <= led_nxt;
      bit_r     <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign led_next     = led_r + 1'b1;
  assign stat.sending = sending_r;
  assign stat.level   = sending_r && (phase_r == PH_HIGH);
  assign stat.done    = ctrl.tick && sending_r && (phase_r == PH_LATCH) && ph_end;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rgbfs_pkg::*;

  localparam int STRIP_MAX = 256;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned WORD_TARGET = 1600;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    in_word_t               w;
    logic                   typed;
    out_word_t              want;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   data;
  } script_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // side band that travels with each offered word
  logic want_typed = 1'b0;
  out_word_t want_word = '0;

  // mirror of the strip state and its timing registers
  logic [23:0] pix_mirror [STRIP_MAX];
  logic        line_busy;
  int unsigned led_at, byte_at, bit_at;
  phase_t      wave_ph;
  logic [15:0] wave_count;
  logic [8:0]  cfg_leds;
  logic [7:0]  t_zero_hi, t_zero_lo, t_one_hi, t_one_lo;
  logic [15:0] t_latch;

  out_word_t   responses_due [$];
  script_row_t script [$];
  int unsigned frames_done = 0;
  int unsigned words_offered = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned rx_cycles = 0;
  int unsigned hold_left = 0;
  logic        pressed = 1'b0;

  rgb_led_strip_frame_serializer #(.LED_SLOTS(STRIP_MAX)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned leds_in_use();
    return (cfg_leds > STRIP_MAX) ? STRIP_MAX : cfg_leds;
  endfunction

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic line_high();
    return line_busy && wave_ph == PH_HIGH;
  endfunction

  function automatic void begin_frame();
    line_busy = 1'b1;
    led_at = 0;
    byte_at = 0;
    bit_at = 0;
    wave_count = '0;
    wave_ph = (leds_in_use() == 0) ? PH_LATCH : PH_HIGH;
  endfunction

  // one tick of the line; returns 1 when the latch gap closes
  function automatic logic advance_tick();
    int unsigned dur;
    logic level_bit;
    if (!line_busy) return 1'b0;
    if (wave_ph == PH_LATCH) begin
      dur = at_least_one(t_latch);
    end else begin
      level_bit = pix_mirror[led_at % STRIP_MAX][8 * (2 - byte_at) + 7 - bit_at];
      if (wave_ph == PH_HIGH) dur = at_least_one(level_bit ? t_one_hi : t_zero_hi);
      else dur = at_least_one(level_bit ? t_one_lo : t_zero_lo);
    end
    wave_count = wave_count + 16'd1;
    if (wave_count != 16'd0 && wave_count < dur) return 1'b0;
    wave_count = '0;
    if (wave_ph == PH_HIGH) begin
      wave_ph = PH_LOW;
      return 1'b0;
    end
    if (wave_ph == PH_LATCH) begin
      line_busy = 1'b0;
      wave_ph = PH_HIGH;
      return 1'b1;
    end
    wave_ph = PH_HIGH;
    if (bit_at < 7) begin
      bit_at++;
      return 1'b0;
    end
    bit_at = 0;
    if (byte_at < 2) begin
      byte_at++;
      return 1'b0;
    end
    byte_at = 0;
    if (led_at + 1 >= leds_in_use()) wave_ph = PH_LATCH;
    else led_at++;
    return 1'b0;
  endfunction

  function automatic out_word_t strip_response(in_word_t w);
    out_word_t r;
    logic [23:0] colour;
    int unsigned n;
    r = '0;
    colour = {w.red, w.green, w.blue};
    if (w.cmd == CMD_TICK) begin
      r.line_level = line_high();
      r.frame_done = advance_tick();
    end else if (line_busy) begin
      r.status = STS_BUSY;
      r.line_level = line_high();
    end else begin
      case (w.cmd)
        CMD_SET: begin
          if (w.led_index >= leds_in_use()) r.status = STS_RANGE;
          else pix_mirror[w.led_index] = colour;
        end
        CMD_FILL: begin
          n = leds_in_use();
          for (int i = 0; i < STRIP_MAX; i++)
            pix_mirror[i] = (i < n && i < w.lit_count) ? colour : 24'd0;
          begin_frame();
        end
        default: begin
          begin_frame();
        end
      endcase
      r.line_level = line_high();
    end
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] c, logic [7:0] idx, logic [23:0] rgb,
                                         logic [8:0] lit);
    in_word_t w;
    w.cmd = c;
    w.led_index = idx;
    {w.red, w.green, w.blue} = rgb;
    w.lit_count = lit;
    return w;
  endfunction

  function automatic in_word_t random_word();
    return make_word(2'($urandom), 8'($urandom), 24'($urandom), 9'($urandom));
  endfunction

  function automatic in_word_t tick_word();
    return make_word(CMD_TICK, 8'($urandom), 24'($urandom), 9'($urandom));
  endfunction

  function automatic out_word_t outcome(logic [1:0] s, logic lvl, logic dn);
    out_word_t r;
    r.status = s;
    r.line_level = lvl;
    r.frame_done = dn;
    return r;
  endfunction

  function automatic void add_word(in_word_t w);
    script.push_back('{ROW_WORD, w, 1'b0, out_word_t'('0), '0, '0});
  endfunction

  function automatic void add_checked(in_word_t w, out_word_t want);
    script.push_back('{ROW_WORD, w, 1'b1, want, '0, '0});
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    script.push_back('{ROW_REG, in_word_t'('0), 1'b0, out_word_t'('0), idx, data});
  endfunction

  task automatic flag_mismatch(string what, out_word_t e, out_word_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected status=%0d level=%0d done=%0d, got status=%0d level=%0d done=%0d",
               $realtime, what, e.status, e.line_level, e.frame_done,
               a.status, a.line_level, a.frame_done);
  endtask

  task automatic offer(in_word_t w, logic typed, out_word_t want);
    while (!(words_offered >= 900 && words_offered < 1200) && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    want_typed <= typed;
    want_word <= want;
    words_offered++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait until every word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (responses_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_LED_COUNT: cfg_leds = data[8:0];
      REG_ZERO_HIGH: t_zero_hi = data[7:0];
      REG_ZERO_LOW:  t_zero_lo = data[7:0];
      REG_ONE_HIGH:  t_one_hi = data[7:0];
      REG_ONE_LOW:   t_one_lo = data[7:0];
      REG_LATCH:     t_latch = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int unsigned k);
    logic [8:0] cnt;
    logic stretched;
    int unsigned span, top_idx, pick, n, lim, start_done;
    settle();
    stretched = (k % 6 == 2);
    if (stretched) begin
      cnt = 9'($urandom_range(256, 511));
      write_reg(REG_LED_COUNT, {7'($urandom), cnt});
      write_reg(REG_ZERO_HIGH, {8'($urandom), 8'd255});
      write_reg(REG_ZERO_LOW, {8'($urandom), 8'($urandom_range(1, 255))});
      write_reg(REG_ONE_HIGH, {8'($urandom), 8'($urandom_range(1, 255))});
      write_reg(REG_ONE_LOW, {8'($urandom), 8'd255});
      write_reg(REG_LATCH, 16'hFFFF);
    end else begin
      // keep frames short so that many of them complete
      cnt = ($urandom_range(9) == 0) ? 9'd0
          : 9'($urandom_range(1, ($urandom_range(3) == 0) ? 4 : 2));
      write_reg(REG_LED_COUNT, {7'($urandom), cnt});
      write_reg(REG_ZERO_HIGH, {8'($urandom), 8'($urandom_range(0, 3))});
      write_reg(REG_ZERO_LOW, {8'($urandom), 8'($urandom_range(0, 3))});
      write_reg(REG_ONE_HIGH, {8'($urandom), 8'($urandom_range(0, 3))});
      write_reg(REG_ONE_LOW, {8'($urandom), 8'($urandom_range(0, 3))});
      write_reg(REG_LATCH, 16'($urandom_range(0, 24)));
    end
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));

    span = (cnt > STRIP_MAX) ? STRIP_MAX : cnt;
    top_idx = (span + 1 > 255) ? 255 : span + 1;
    if ($urandom_range(99) < 15) repeat (8) offer(random_word(), 1'b0, '0);
    repeat ($urandom_range(0, 4))
      offer(make_word(CMD_SET, 8'($urandom_range(0, top_idx)), 24'($urandom), 9'($urandom)),
            1'b0, '0);
    pick = $urandom_range(99);
    if (pick < 30)
      offer(make_word(CMD_FILL, 8'($urandom), 24'($urandom),
                      $urandom_range(1) ? 9'($urandom) : 9'($urandom_range(0, span + 1))),
            1'b0, '0);
    else if (pick < 85)
      offer(make_word(CMD_SHOW, 8'($urandom), 24'($urandom), 9'($urandom)), 1'b0, '0);

    lim = stretched ? 120 : ((pick < 85) ? 650 : 40);
    start_done = frames_done;
    n = 0;
    while (frames_done == start_done && n < lim && words_offered < WORD_TARGET) begin
      if ($urandom_range(99) < 4) offer(random_word(), 1'b0, '0);
      else offer(tick_word(), 1'b0, '0);
      n++;
    end
    repeat ($urandom_range(0, 3)) offer(tick_word(), 1'b0, '0);
  endtask

  always @(posedge clk) begin : watch
    out_word_t predicted, due;
    if (rst_n && in_valid && !in_stall) begin
      predicted = strip_response(in_word);
      if (predicted.frame_done) frames_done <= frames_done + 1;
      responses_due.push_back(want_typed ? want_word : predicted);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (responses_due.size() == 0) begin
        flag_mismatch("word with nothing pending", '0, out_word);
      end else begin
        due = responses_due.pop_front();
        if (out_word.status !== due.status || out_word.line_level !== due.line_level ||
            out_word.frame_done !== due.frame_done)
          flag_mismatch("word differs", due, out_word);
      end
    end
  end

  always @(posedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressed && rx_cycles >= 1500 && in_valid) begin
      // back up the whole pipe while words keep coming
      pressed <= 1'b1;
      hold_left <= 1000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(rx_cycles >= 2500 && rx_cycles < 3300) && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    for (int i = 0; i < STRIP_MAX; i++) pix_mirror[i] = '0;
    line_busy = 1'b0;
    led_at = 0;
    byte_at = 0;
    bit_at = 0;
    wave_ph = PH_HIGH;
    wave_count = '0;
    cfg_leds = 9'd256;
    t_zero_hi = 8'd3;
    t_zero_lo = 8'd9;
    t_one_hi = 8'd9;
    t_one_lo = 8'd3;
    t_latch = 16'd500;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_checked(tick_word(), outcome(STS_OK, 1'b0, 1'b0));
    add_checked(make_word(CMD_SET, 8'd0, 24'hFF00FF, 9'd0), outcome(STS_OK, 1'b0, 1'b0));
    add_checked(make_word(CMD_SET, 8'd255, 24'h00FF00, 9'h1FF), outcome(STS_OK, 1'b0, 1'b0));
    add_reg(REG_LATCH, 16'd0);
    add_reg(REG_LED_COUNT, 16'd0);
    add_reg(REG_SPARE_HI, 16'hFFFF);
    // no LEDs: every set is out of range and a frame is the latch gap alone
    add_checked(make_word(CMD_SET, 8'd0, 24'h123456, 9'd0), outcome(STS_RANGE, 1'b0, 1'b0));
    add_checked(make_word(CMD_SHOW, 8'd0, 24'd0, 9'd0), outcome(STS_OK, 1'b0, 1'b0));
    add_checked(make_word(CMD_SET, 8'd1, 24'hFFFFFF, 9'd0), outcome(STS_BUSY, 1'b0, 1'b0));
    add_checked(tick_word(), outcome(STS_OK, 1'b0, 1'b1));
    add_checked(tick_word(), outcome(STS_OK, 1'b0, 1'b0));
    add_checked(make_word(CMD_FILL, 8'd0, 24'hFFFFFF, 9'h1FF), outcome(STS_OK, 1'b0, 1'b0));
    add_checked(make_word(CMD_SHOW, 8'd0, 24'd0, 9'd0), outcome(STS_BUSY, 1'b0, 1'b0));
    add_checked(tick_word(), outcome(STS_OK, 1'b0, 1'b1));
    add_reg(REG_LED_COUNT, 16'd256);
    add_reg(REG_ZERO_HIGH, 16'd0);
    add_reg(REG_ZERO_LOW, 16'd0);
    add_reg(REG_ONE_HIGH, 16'd1);
    add_reg(REG_ONE_LOW, 16'd0);
    add_word(make_word(CMD_SET, 8'd200, 24'h123456, 9'd0));
    add_word(make_word(CMD_SET, 8'd0, 24'h800001, 9'd0));
    add_checked(make_word(CMD_FILL, 8'd7, 24'h800001, 9'd1), outcome(STS_OK, 1'b1, 1'b0));
    add_checked(make_word(CMD_FILL, 8'd0, 24'h00FF00, 9'd0), outcome(STS_BUSY, 1'b1, 1'b0));
    add_checked(make_word(CMD_SHOW, 8'd0, 24'd0, 9'd0), outcome(STS_BUSY, 1'b1, 1'b0));
    add_checked(make_word(CMD_SET, 8'd5, 24'h0000FF, 9'd0), outcome(STS_BUSY, 1'b1, 1'b0));
    repeat (4) add_word(tick_word());
    // shrink the strip mid frame: the latch gap follows the current LED
    add_reg(REG_LED_COUNT, 16'd1);
    add_reg(REG_LATCH, 16'd2);
    repeat (3) add_word(tick_word());

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        offer(script[i].w, script[i].typed, script[i].want);
      end
    end

    k = 0;
    while (words_offered < WORD_TARGET) begin
      run_phase(k);
      k++;
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
src/rgbfs_pkg.sv
src/rgbfs_store.sv
src/rgbfs_wave.sv
src/rgb_led_strip_frame_serializer.sv
tb/tb.sv
